// File: design/xed_pkg.sv
// shared types and entity tables for the xml entity decoder
package xed_pkg;

  localparam int NumEnt      = 5;
  localparam int MaxPending  = 5;
  localparam int MaxResults  = MaxPending + 1;
  localparam int NameLen     = 6;

  localparam logic [7:0] CharAmp = 8'h26;

  // entity names, byte i of a name at element [i]
  localparam logic [NameLen-1:0][7:0] EntName [NumEnt] = '{
    {8'h00, 8'h3b, 8'h70, 8'h6d, 8'h61, 8'h26},  // &amp;
    {8'h3b, 8'h73, 8'h6f, 8'h70, 8'h61, 8'h26},  // &apos;
    {8'h3b, 8'h74, 8'h6f, 8'h75, 8'h71, 8'h26},  // &quot;
    {8'h00, 8'h00, 8'h3b, 8'h74, 8'h6c, 8'h26},  // &lt;
    {8'h00, 8'h00, 8'h3b, 8'h74, 8'h67, 8'h26}   // &gt;
  };
  localparam logic [2:0] EntLen  [NumEnt] = '{3'd5, 3'd6, 3'd6, 3'd4, 3'd4};
  localparam logic [7:0] EntChar [NumEnt] = '{8'h26, 8'h27, 8'h22, 8'h3c, 8'h3e};

  // result bytes caused by one input beat
  typedef struct packed {
    logic [MaxResults-1:0][7:0] data;
    logic [2:0]                 count;
    logic                       done;
  } xed_result_t;

endpackage

// File: design/xed_match.sv
// pending buffer and entity matcher: turns one input byte into its result list
module xed_match import xed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  text_byte,
  input  logic        text_end,
  output xed_result_t result
);

  logic [7:0] pend [MaxPending];
  logic [2:0] pend_count;
  logic [2:0] pend_count_next;
  logic       wr_en;
  logic [2:0] wr_idx;

  logic [2:0] n;
  logic       ok;
  logic       prefix_any;
  logic       full_any;
  logic [7:0] full_char;
  logic       is_amp;
  logic       flush_pend;
  logic       x_valid;
  logic [7:0] x_byte;

  // compare held bytes plus the new byte against every entity prefix
  always_comb begin
    n = (pend_count > 3'(MaxPending)) ? 3'(MaxPending) : pend_count;
    prefix_any = 1'b0;
    full_any   = 1'b0;
    full_char  = 8'h00;
    ok         = 1'b0;
    for (int e = 0; e < NumEnt; e++) begin
      ok = ({1'b0, n} + 4'd1) <= {1'b0, EntLen[e]};
      for (int i = 0; i < MaxPending; i++) begin
        if ((3'(i) < n) && (pend[i] != EntName[e][i])) begin
          ok = 1'b0;
        end
      end
      if (EntName[e][n] != text_byte) begin
        ok = 1'b0;
      end
      if (ok) begin
        prefix_any = 1'b1;
        if ((({1'b0, n} + 4'd1) == {1'b0, EntLen[e]}) && !full_any) begin
          full_any  = 1'b1;
          full_char = EntChar[e];
        end
      end
    end
  end

  // pick what goes out and what stays held
  always_comb begin
    is_amp          = (text_byte == CharAmp);
    flush_pend      = 1'b0;
    x_valid         = 1'b0;
    x_byte          = text_byte;
    pend_count_next = 3'd0;
    wr_en           = 1'b0;
    wr_idx          = 3'd0;
    if (n == 3'd0) begin
      x_valid         = !is_amp || text_end;
      pend_count_next = (is_amp && !text_end) ? 3'd1 : 3'd0;
      wr_en           = is_amp;
    end else if (full_any) begin
      x_valid = 1'b1;
      x_byte  = full_char;
    end else if (prefix_any && (n < 3'(MaxPending))) begin
      flush_pend      = text_end;
      x_valid         = text_end;
      pend_count_next = text_end ? 3'd0 : n + 3'd1;
      wr_en           = 1'b1;
      wr_idx          = n;
    end else begin
      flush_pend      = 1'b1;
      x_valid         = !is_amp || text_end;
      pend_count_next = (is_amp && !text_end) ? 3'd1 : 3'd0;
      wr_en           = is_amp;
    end
  end

  // assemble the result list: held bytes first, then the single byte
  always_comb begin
    for (int i = 0; i < MaxResults; i++) begin
      if (flush_pend && (3'(i) < n)) begin
        result.data[i] = pend[i];
      end else begin
        result.data[i] = x_byte;
      end
    end
    result.count = (flush_pend ? n : 3'd0) + {2'b00, x_valid};
    result.done  = text_end;
  end

  // held count
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= 3'd0;
    end else if (accept) begin
      pend_count <= pend_count_next;
    end
  end

  // held bytes
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      pend[wr_idx] <= text_byte;
    end
  end

endmodule

// File: design/xed_emit.sv
// result shift register: sends the bytes of one input beat one per cycle while m_axis_tready is high
module xed_emit import xed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  xed_result_t result,
  output logic        can_load,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser
);

  logic [MaxResults-1:0][7:0] buffer;
  logic [2:0]                 remain;
  logic                       done;
  logic                       out_beat;

  assign out_beat      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (remain != 3'd0);
  assign m_axis_tdata  = buffer[0];
  assign m_axis_tlast  = (remain == 3'd1);
  assign m_axis_tuser  = (remain == 3'd1) && done;

  // free once the last byte of the current list leaves
  assign can_load = (remain == 3'd0) || ((remain == 3'd1) && m_axis_tready);

  // remaining count
  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= 3'd0;
    end else if (load) begin
      remain <= result.count;
    end else if (out_beat) begin
      remain <= remain - 3'd1;
    end
  end

  // byte shift line
  always_ff @(posedge clk) begin
    if (load) begin
      buffer <= result.data;
      done   <= result.done;
    end else if (out_beat) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        buffer[i] <= buffer[i+1];
      end
    end
  end

endmodule

// File: design/xml_entity_decoder.sv
// top level of the xml predefined entity decoder
// Decodes &amp; &apos; &quot; &lt; &gt; in a byte stream, one text byte per input beat
// (tlast marks the final byte of a text). Each input beat is matched in the cycle it is
// accepted and its results (zero to six bytes) are loaded into an output shift register
// that sends one byte per cycle while m_axis_tready is high; m_axis_tlast marks the
// last byte caused by an input beat and m_axis_tuser the final byte of the text. A
// beat giving at most one byte keeps s_axis_tready high if m_axis_tready is high, so
// plain text runs at one byte per cycle; longer lists hold s_axis_tready low as they drain.
module xml_entity_decoder import xed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte
  input  logic        s_axis_tlast,   // text_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,   // run_last
  output logic [0:0]  m_axis_tuser    // text_done
);

  xed_result_t result;
  logic        accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  // matcher with the pending buffer
  xed_match u_match (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (s_axis_tdata),
    .text_end  (s_axis_tlast),
    .result    (result)
  );

  // output serializer
  xed_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .result        (result),
    .can_load      (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: bench/tb_top.sv
// testbench for the xml entity decoder: directed and random text checked against a byte predictor
`timescale 1ns / 100ps

module tb_top;

  localparam logic [7:0] AmpByte    = 8'h26;
  localparam int         NumNames   = 5;
  localparam int         HoldDepth  = 5;
  localparam int         StallLimit = 400;
  localparam int         DrainWait  = 20;
  localparam int         RandItems  = 220;

  // one decoded output beat
  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       done;
  } dec_beat_t;

  // tracks the entity decoding of the text and checks each output beat
  class entity_scoreboard;
    string       ent_name [NumNames];
    logic [7:0]  ent_glyph [NumNames];
    logic [7:0]  held [HoldDepth];
    int          held_n;
    logic [7:0]  run_bytes [$];
    dec_beat_t   decoded_q [$];
    int unsigned fails;
    int unsigned checked;

    function new();
      ent_name  = '{"&amp;", "&apos;", "&quot;", "&lt;", "&gt;"};
      ent_glyph = '{8'h26, 8'h27, 8'h22, 8'h3c, 8'h3e};
      held_n    = 0;
      fails     = 0;
      checked   = 0;
    endfunction

    // held bytes leave in arrival order
    function void flush_held();
      int i;
      for (i = 0; i < held_n; i++) run_bytes.push_back(held[i]);
      held_n = 0;
    endfunction

    // byte seen with nothing held
    function void take_byte(logic [7:0] b);
      if (b == AmpByte) begin
        held[0] = b;
        held_n  = 1;
      end else begin
        run_bytes.push_back(b);
      end
    endfunction

    // work out the beats caused by one accepted text byte
    function void note_byte(logic [7:0] b, logic fin);
      int        n, e, i, len, hit;
      bit        partial, same;
      dec_beat_t r;
      run_bytes.delete();
      n = held_n;
      if (n == 0) begin
        take_byte(b);
      end else begin
        partial = 0;
        hit     = -1;
        for (e = 0; e < NumNames; e++) begin
          len = ent_name[e].len();
          if (n + 1 <= len) begin
            same = (ent_name[e][n] == b);
            for (i = 0; i < n; i++)
              if (held[i] != ent_name[e][i]) same = 0;
            if (same) begin
              partial = 1;
              if (n + 1 == len) hit = e;
            end
          end
        end
        if (hit >= 0) begin
          held_n = 0;
          run_bytes.push_back(ent_glyph[hit]);
        end else if (partial && n < HoldDepth) begin
          held[n] = b;
          held_n  = n + 1;
        end else begin
          flush_held();
          take_byte(b);
        end
      end
      if (fin) flush_held();
      foreach (run_bytes[k]) begin
        r.data     = run_bytes[k];
        r.run_last = (k == run_bytes.size() - 1);
        r.done     = r.run_last && fin;
        decoded_q.push_back(r);
      end
    endfunction

    function int outstanding();
      return decoded_q.size();
    endfunction

    task report(string what);
      if (fails < 40) $display("%0t mismatch: %s", $time, what);
      fails++;
    endtask

    // compare one output beat with the oldest expected beat
    task check_out(logic [7:0] d, logic l, logic u);
      dec_beat_t want;
      checked++;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected beat data %02h last %0b done %0b", d, l, u));
        return;
      end
      want = decoded_q.pop_front();
      if (d !== want.data)
        report($sformatf("data %02h, wanted %02h", d, want.data));
      if (l !== want.run_last)
        report($sformatf("run_last %0b, wanted %0b (data %02h)", l, want.run_last, want.data));
      if (u !== want.done)
        report($sformatf("text_done %0b, wanted %0b (data %02h)", u, want.done, want.data));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // text_byte
  logic       s_axis_tlast;   // text_end
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // out_byte
  logic       m_axis_tlast;   // run_last
  logic [0:0] m_axis_tuser;   // text_done

  entity_scoreboard sb = new();
  int               sent_n = 0;
  int               idle_cycles = 0;

  xml_entity_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= StallLimit) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // send one text byte, with a random gap before it
  task send_byte(logic [7:0] b, logic fin);
    int gap;
    gap = ((sent_n / 40) % 3 == 1) ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(b, fin);
    sent_n++;
  endtask

  // send a string, text_end on its last byte if asked
  task send_text(string s, logic fin);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  // one random token: whole entity, broken entity, plain byte or ampersand run
  task send_token();
    int    kind, e, cut, i;
    string nm;
    kind = $urandom_range(0, 9);
    e    = $urandom_range(0, NumNames - 1);
    nm   = sb.ent_name[e];
    if (kind <= 3) begin
      for (i = 0; i < nm.len(); i++) send_byte(nm[i], $urandom_range(0, 15) == 0);
    end else if (kind <= 5) begin
      cut = $urandom_range(1, nm.len() - 1);
      for (i = 0; i < cut; i++) send_byte(nm[i], $urandom_range(0, 19) == 0);
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end else if (kind <= 8) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
    end else begin
      send_byte(AmpByte, 1'b0);
      send_byte(AmpByte, $urandom_range(0, 3) == 0);
    end
  endtask

  // stop sending and hold off until every expected beat has come out
  task wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // output side: random stalls, check each beat
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = ((sb.checked / 50) % 3 == 2) ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk);
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && !rst));
      sb.check_out(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
    end
  end

  // reset, directed text, random text, drain
  initial begin
    bit paused;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    paused        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // entities, a five-byte flush with the breaking byte, byte extremes
    send_text("&gt;&lt;&amp;&quotX", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    // end of text with bytes held, and a lone ampersand at the end
    send_text("&apos", 1'b1);
    send_text("&", 1'b1);
    wait_drained();

    while (sent_n < RandItems) begin
      send_token();
      if (!paused && sent_n >= 140) begin
        wait_drained();
        paused = 1;
      end
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (DrainWait) @(posedge clk);
    if (sb.fails == 0 && sb.outstanding() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

// File: sim.f
design/xed_pkg.sv
design/xed_match.sv
design/xed_emit.sv
design/xml_entity_decoder.sv
bench/tb_top.sv
